// ===== design/tinted_sprite_compositor_assert.svh =====
// assertion macros for the sprite compositor
// expects clk and arst_n in the scope where a macro is used
`ifndef TINTED_SPRITE_COMPOSITOR_ASSERT_SVH
`define TINTED_SPRITE_COMPOSITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TSC_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tsc assertion failed");
// next-cycle implication
`define TSC_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tsc assertion failed");
`else
`define TSC_ASSERT_IMP(lbl, pre, post)
`define TSC_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== design/tsc_pkg.sv =====
// shared types, constants and codes of the sprite compositor
// no dependencies
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int CANVAS_PIXELS_DEF   = 65536;
	localparam int BYTES_PER_PIXEL_DEF = 4;

	localparam int CH_W      = 8;
	localparam int IDX_W     = 16;
	localparam int POS_W     = 12;
	localparam int DIM_W     = 13;
	localparam int CW_W      = 11;
	localparam int SCALE_W   = 5;
	localparam int FMT_W     = 2;
	localparam int ROW_W     = 16;
	localparam int CCOL_W    = 14;
	localparam int SADDR_W   = 27;
	localparam int PROD_W    = 2 * CH_W;
	localparam int WORD_BITS = 4 * CH_W;
	localparam int DIV_CNT_W = $clog2(DIM_W);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [CH_W-1:0]    CH_MAX     = 8'hFF;
	localparam logic [CW_W-1:0]    CANVAS_RST = 11'd256;
	localparam logic [CH_W-1:0]    TINT_RST   = 8'd255;
	localparam logic [CH_W-1:0]    AREF_RST   = 8'd0;
	localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd1;
	localparam logic [FMT_W-1:0]   FMT_RST    = 2'd1;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_BEGIN = 2'd1,
		ACT_PIXEL = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_CANVAS_WIDTH  = 3'd0,
		REG_CANVAS_HEIGHT = 3'd1,
		REG_TINT_RED      = 3'd2,
		REG_TINT_GREEN    = 3'd3,
		REG_TINT_BLUE     = 3'd4,
		REG_ALPHA_REF     = 3'd5,
		REG_SCALE         = 3'd6,
		REG_FORMAT        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_DRAW  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PL_IDLE = 2'd0,
		PL_DIV  = 2'd1,
		PL_TOP  = 2'd2,
		PL_ADDR = 2'd3
	} place_state_t;

	typedef struct packed {
		logic [1:0]              action;
		logic [IDX_W-1:0]        pixel_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [DIM_W-1:0]        sprite_width;
		logic [DIM_W-1:0]        sprite_height;
		logic [CH_W-1:0]         red;
		logic [CH_W-1:0]         green;
		logic [CH_W-1:0]         blue;
		logic [CH_W-1:0]         alpha;
	} tsc_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} tsc_out_t;

	typedef struct packed {
		logic                    start;
		logic [DIM_W-1:0]        h_adj;
		logic signed [POS_W-1:0] py_eff;
		logic                    flip;
		logic [SCALE_W-1:0]      scale;
		logic [CW_W-1:0]         col_base;
	} place_req_t;

	typedef struct packed {
		logic                      done;
		logic [DIM_W-1:0]          row_limit;
		logic signed [ROW_W-1:0]   top_row;
		logic signed [SADDR_W-1:0] row_start;
	} place_res_t;

endpackage

// ===== design/tsc_stream_if.sv =====
// valid/ready stream channel carrying one payload per transfer
// payload type comes from tsc_pkg at the point of instantiation
`timescale 1ns / 1ps

interface tsc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/tsc_canvas_ram.sv =====
// canvas word memory, one write port and one registered read port
// no package types used
`timescale 1ns / 1ps

module tsc_canvas_ram #(
	parameter int DEPTH = tsc_pkg::CANVAS_PIXELS_DEF,
	parameter int WIDTH = 8 * tsc_pkg::BYTES_PER_PIXEL_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/tsc_place.sv =====
// sprite placement: row count by restoring division, top row and first row address
// uses tsc_pkg request and result structs
`timescale 1ns / 1ps

module tsc_place (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsc_pkg::place_req_t          req,
	input  logic [tsc_pkg::CW_W-1:0]     canvas_width,
	input  logic [tsc_pkg::CW_W-1:0]     canvas_height,
	output logic                         busy,
	output tsc_pkg::place_res_t          res
);
	import tsc_pkg::*;

	place_state_t state_q, state_d;

	logic [DIM_W-1:0]          dvd_q;
	logic [SCALE_W-1:0]        rem_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic [SCALE_W-1:0]        sc_q;
	logic signed [POS_W-1:0]   py_q;
	logic                      flip_q;
	logic [CW_W-1:0]           col_base_q;
	logic signed [ROW_W-1:0]   top_q;

	logic [SCALE_W:0]          shifted;
	logic                      ge;
	logic [SCALE_W:0]          rem_n;
	logic signed [ROW_W-1:0]   top_n;
	logic signed [SADDR_W:0]   prod;

	// one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, dvd_q[DIM_W-1]};
		ge      = shifted >= {1'b0, sc_q};
		rem_n   = ge ? (shifted - {1'b0, sc_q}) : shifted;
	end

	always_comb begin
		top_n = $signed({{(ROW_W-CW_W){1'b0}}, canvas_height})
			- $signed({{(ROW_W-POS_W){py_q[POS_W-1]}}, py_q})
			- $signed(ROW_W'(1))
			- $signed({{(ROW_W-DIM_W){1'b0}}, dvd_q});
		prod  = top_q * $signed({1'b0, canvas_width});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		busy          = 1'b1;
		res.done      = 1'b0;
		res.row_limit = dvd_q;
		res.top_row   = top_q;
		res.row_start = prod[SADDR_W-1:0] + {{(SADDR_W-CW_W){1'b0}}, col_base_q};
		unique case (state_q)
			PL_IDLE: begin
				busy = 1'b0;
				if (req.start) begin
					state_d = PL_DIV;
				end
			end
			PL_DIV: begin
				if (cnt_q == '0) begin
					state_d = PL_TOP;
				end
			end
			PL_TOP: begin
				state_d = PL_ADDR;
			end
			PL_ADDR: begin
				res.done = 1'b1;
				state_d  = PL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			PL_IDLE: begin
				dvd_q      <= req.h_adj;
				rem_q      <= '0;
				cnt_q      <= DIV_CNT_W'(DIM_W - 1);
				sc_q       <= req.scale;
				py_q       <= req.py_eff;
				flip_q     <= req.flip;
				col_base_q <= req.col_base;
			end
			PL_DIV: begin
				dvd_q <= {dvd_q[DIM_W-2:0], ge};
				rem_q <= rem_n[SCALE_W-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			PL_TOP: begin
				top_q <= flip_q ? top_n : '0;
			end
			PL_ADDR: begin
			end
		endcase
	end
endmodule

// ===== design/tinted_sprite_compositor.sv =====
// tinted sprite compositor top level: config registers, sprite walk, canvas rmw pipe
// uses tsc_pkg, tsc_stream_if, tsc_place, tsc_canvas_ram, assertion macro header
// canvas write, sprite pixel and canvas read items are taken back to back while
// placement is idle and the fifo has room; read results pass the registered memory
// read; a non-empty begin holds input for 13 divide steps, top row and row address
// reset clears control state and registers; canvas contents stay undefined until written
`timescale 1ns / 1ps
`include "tinted_sprite_compositor_assert.svh"

module tinted_sprite_compositor #(
	parameter int CANVAS_PIXELS   = tsc_pkg::CANVAS_PIXELS_DEF,
	parameter int BYTES_PER_PIXEL = tsc_pkg::BYTES_PER_PIXEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tsc_stream_if.sink                  item,
	tsc_stream_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsc_pkg::PADDR_W-1:0] paddr,
	input  logic [tsc_pkg::PDATA_W-1:0] pwdata,
	output logic [tsc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import tsc_pkg::*;

	localparam int AW     = $clog2(CANVAS_PIXELS);
	localparam int WORD_W = CH_W * BYTES_PER_PIXEL;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [CW_W-1:0]    cw_q, ch_q;
	logic [2:0][CH_W-1:0] tint_q;     // [0] red, [1] green, [2] blue
	logic [CH_W-1:0]    aref_q;
	logic [SCALE_W-1:0] scale_q;
	logic [FMT_W-1:0]   fmt_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q    <= CANVAS_RST;
			ch_q    <= CANVAS_RST;
			tint_q  <= {TINT_RST, TINT_RST, TINT_RST};
			aref_q  <= AREF_RST;
			scale_q <= SCALE_RST;
			fmt_q   <= FMT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CANVAS_WIDTH:  cw_q      <= pwdata[CW_W-1:0];
				REG_CANVAS_HEIGHT: ch_q      <= pwdata[CW_W-1:0];
				REG_TINT_RED:      tint_q[0] <= pwdata[CH_W-1:0];
				REG_TINT_GREEN:    tint_q[1] <= pwdata[CH_W-1:0];
				REG_TINT_BLUE:     tint_q[2] <= pwdata[CH_W-1:0];
				REG_ALPHA_REF:     aref_q    <= pwdata[CH_W-1:0];
				REG_SCALE:         scale_q   <= pwdata[SCALE_W-1:0];
				REG_FORMAT:        fmt_q     <= pwdata[FMT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CANVAS_WIDTH:  prdata = PDATA_W'(cw_q);
			REG_CANVAS_HEIGHT: prdata = PDATA_W'(ch_q);
			REG_TINT_RED:      prdata = PDATA_W'(tint_q[0]);
			REG_TINT_GREEN:    prdata = PDATA_W'(tint_q[1]);
			REG_TINT_BLUE:     prdata = PDATA_W'(tint_q[2]);
			REG_ALPHA_REF:     prdata = PDATA_W'(aref_q);
			REG_SCALE:         prdata = PDATA_W'(scale_q);
			REG_FORMAT:        prdata = PDATA_W'(fmt_q);
		endcase
	end

	// ------------------------------------------------------------------
	// input transfer and item decode
	// ------------------------------------------------------------------
	logic    acc;
	action_t act;
	logic    place_busy;
	logic    credit_ok;

	op_t                  op_s1;
	logic [OUT_CNT_W-1:0] ofifo_cnt_q;

	// an item is only taken when the result fifo has room for a read and
	// for the read already in flight in stage 1
	assign credit_ok  = (ofifo_cnt_q + OUT_CNT_W'(op_s1 == OP_READ)) < OUT_CNT_W'(OUT_DEPTH);
	assign item.ready = !place_busy && credit_ok;
	assign acc        = item.valid && item.ready;
	assign act        = action_t'(item.data.action);

	logic [WORD_BITS-1:0] idx_wide;
	logic                 idx_hit;

	assign idx_wide = WORD_BITS'(item.data.pixel_index);
	assign idx_hit  = idx_wide < WORD_BITS'(CANVAS_PIXELS);

	// ------------------------------------------------------------------
	// begin: horizontal placement and vertical clip decided on the spot,
	// the row count and first row address come from the placement unit
	// ------------------------------------------------------------------
	logic                    begin_acc;
	logic                    begin_empty;
	logic [SCALE_W-1:0]      sc_eff;
	logic signed [POS_W+2:0] px_sum;
	logic signed [DIM_W:0]   h_sum;
	logic [CW_W-1:0]         begin_col_base;
	logic [DIM_W-1:0]        h_adj;
	logic signed [POS_W-1:0] py_eff;
	place_req_t              place_req;
	place_res_t              place_res;

	always_comb begin
		begin_acc   = acc && (act == ACT_BEGIN);
		begin_empty = (item.data.sprite_width == '0) || (item.data.sprite_height == '0);
		sc_eff      = (scale_q == '0) ? SCALE_W'(1) : scale_q;

		// sprite falling off the right edge or starting at negative x goes to column 0
		px_sum = {{3{item.data.pos_x[POS_W-1]}}, item.data.pos_x}
			+ $signed({2'b00, item.data.sprite_width});
		if (item.data.pos_x[POS_W-1] || (px_sum > $signed({4'd0, cw_q}))) begin
			begin_col_base = '0;
		end else begin
			begin_col_base = item.data.pos_x[CW_W-1:0];
		end

		// negative y trims the height (floor at zero) and starts at y zero
		h_sum = $signed({1'b0, item.data.sprite_height})
			+ {{(DIM_W+1-POS_W){item.data.pos_y[POS_W-1]}}, item.data.pos_y};
		if (item.data.pos_y[POS_W-1]) begin
			h_adj  = h_sum[DIM_W] ? '0 : h_sum[DIM_W-1:0];
			py_eff = '0;
		end else begin
			h_adj  = item.data.sprite_height;
			py_eff = item.data.pos_y;
		end

		place_req.start    = begin_acc && !begin_empty;
		place_req.h_adj    = h_adj;
		place_req.py_eff   = py_eff;
		place_req.flip     = item.data.pos_y != '0;
		place_req.scale    = sc_eff;
		place_req.col_base = begin_col_base;
	end

	tsc_place u_place (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (place_req),
		.canvas_width  (cw_q),
		.canvas_height (ch_q),
		.busy          (place_busy),
		.res           (place_res)
	);

	// ------------------------------------------------------------------
	// sprite walk: column/row counters with decimation phases; canvas row,
	// column and address are stepped instead of multiplied per pixel
	// ------------------------------------------------------------------
	logic                      draw_active_q;
	logic [DIM_W-1:0]          spr_w_q, spr_h_q;
	logic [SCALE_W-1:0]        spr_sc_q;
	logic [CW_W-1:0]           col_base_q;
	logic [DIM_W-1:0]          col_q, row_q;
	logic [SCALE_W-1:0]        col_ph_q, row_ph_q;
	logic [DIM_W-1:0]          sampled_q, row_limit_q;
	logic signed [ROW_W-1:0]   crow_q;
	logic [CCOL_W-1:0]         ccol_q;
	logic signed [SADDR_W-1:0] row_start_q, addr_q;

	logic                      px_acc;
	logic                      col_last, row_last, col_wrap, row_wrap;
	logic                      addr_hit, in_canvas, kept, alpha_pass, draw_go;
	logic signed [SADDR_W-1:0] cw_ext;

	always_comb begin
		px_acc   = acc && (act == ACT_PIXEL) && draw_active_q;
		col_last = ({1'b0, col_q} + 1'b1) >= {1'b0, spr_w_q};
		row_last = ({1'b0, row_q} + 1'b1) >= {1'b0, spr_h_q};
		col_wrap = col_ph_q == (spr_sc_q - 1'b1);
		row_wrap = row_ph_q == (spr_sc_q - 1'b1);
		cw_ext   = $signed({{(SADDR_W-CW_W){1'b0}}, cw_q});

		addr_hit  = !addr_q[SADDR_W-1]
			&& (WORD_BITS'(addr_q[SADDR_W-2:0]) < WORD_BITS'(CANVAS_PIXELS));
		in_canvas = !crow_q[ROW_W-1]
			&& (crow_q < $signed({{(ROW_W-CW_W){1'b0}}, ch_q}))
			&& (ccol_q < {{(CCOL_W-CW_W){1'b0}}, cw_q})
			&& addr_hit;
		kept       = (col_ph_q == '0) && (row_ph_q == '0) && (sampled_q < row_limit_q)
			&& in_canvas;
		alpha_pass = !fmt_q[0] || (item.data.alpha >= aref_q);
		draw_go    = px_acc && kept && alpha_pass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_active_q <= 1'b0;
			spr_w_q       <= '0;
			spr_h_q       <= '0;
			spr_sc_q      <= SCALE_W'(1);
			col_base_q    <= '0;
			col_q         <= '0;
			row_q         <= '0;
			col_ph_q      <= '0;
			row_ph_q      <= '0;
			sampled_q     <= '0;
			row_limit_q   <= '0;
			crow_q        <= '0;
			ccol_q        <= '0;
			row_start_q   <= '0;
			addr_q        <= '0;
		end else if (begin_acc) begin
			// a begin always stops the current sprite, even an empty one
			draw_active_q <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			col_ph_q      <= '0;
			row_ph_q      <= '0;
			sampled_q     <= '0;
			if (!begin_empty) begin
				spr_w_q    <= item.data.sprite_width;
				spr_h_q    <= item.data.sprite_height;
				spr_sc_q   <= sc_eff;
				col_base_q <= begin_col_base;
			end
		end else if (place_res.done) begin
			draw_active_q <= 1'b1;
			row_limit_q   <= place_res.row_limit;
			crow_q        <= place_res.top_row;
			ccol_q        <= CCOL_W'(col_base_q);
			row_start_q   <= place_res.row_start;
			addr_q        <= place_res.row_start;
		end else if (px_acc) begin
			if (col_last) begin
				col_q    <= '0;
				col_ph_q <= '0;
				ccol_q   <= CCOL_W'(col_base_q);
				// only a sampled row advances the canvas row
				if (row_ph_q == '0) begin
					sampled_q   <= sampled_q + 1'b1;
					crow_q      <= crow_q + $signed(ROW_W'(1));
					row_start_q <= row_start_q + cw_ext;
					addr_q      <= row_start_q + cw_ext;
				end else begin
					addr_q <= row_start_q;
				end
				row_q    <= row_q + 1'b1;
				row_ph_q <= row_wrap ? '0 : (row_ph_q + 1'b1);
				if (row_last) begin
					draw_active_q <= 1'b0;
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (col_wrap) begin
					col_ph_q <= '0;
					ccol_q   <= ccol_q + 1'b1;
					addr_q   <= addr_q + $signed(SADDR_W'(1));
				end else begin
					col_ph_q <= col_ph_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 0: pick the operation and issue the canvas read
	// ------------------------------------------------------------------
	op_t                  op_s0;
	logic [AW-1:0]        addr_s0;
	logic [3:0][CH_W-1:0] ch_s0;       // [0..2] color, [3] alpha

	always_comb begin
		op_s0 = OP_NONE;
		if (acc && (act == ACT_WRITE) && idx_hit) begin
			op_s0 = OP_WRITE;
		end else if (acc && (act == ACT_READ)) begin
			op_s0 = OP_READ;
		end else if (draw_go) begin
			op_s0 = OP_DRAW;
		end

		addr_s0 = (op_s0 == OP_DRAW) ? addr_q[AW-1:0] : idx_wide[AW-1:0];

		// sprite pixels swap red and blue unless the direct order is set
		if ((op_s0 == OP_DRAW) && !fmt_q[1]) begin
			ch_s0 = {item.data.alpha, item.data.red, item.data.green, item.data.blue};
		end else begin
			ch_s0 = {item.data.alpha, item.data.blue, item.data.green, item.data.red};
		end
	end

	logic                 ram_re, ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_W-1:0]    ram_wdata, ram_rdata;
	logic [WORD_BITS-1:0] s2_word;

	assign ram_re = (op_s0 == OP_DRAW) || ((op_s0 == OP_READ) && idx_hit);

	tsc_canvas_ram #(
		.DEPTH (CANVAS_PIXELS),
		.WIDTH (WORD_W)
	) u_canvas (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_s0),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// stage 1: read data arrives, forwarded from the two older writes,
	// tint and inverse-alpha products formed
	// ------------------------------------------------------------------
	logic [AW-1:0]        addr_s1;
	logic [3:0][CH_W-1:0] ch_s1;
	logic                 hit_s1, blend_s1;
	logic [CH_W-1:0]      inv_s1;

	op_t                  op_s2;
	logic [AW-1:0]        addr_s2;
	logic [2:0][PROD_W-1:0] p_s2, q_s2;
	logic [WORD_BITS-1:0] wr_word_s2;

	logic                 s3_valid_q;
	logic [AW-1:0]        s3_addr_q;
	logic [WORD_BITS-1:0] s3_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= op_s0;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= addr_s0;
		ch_s1    <= ch_s0;
		hit_s1   <= idx_hit;
		blend_s1 <= fmt_q[0];
		inv_s1   <= CH_MAX - item.data.alpha;
	end

	logic [WORD_BITS-1:0]   fwd_word;
	logic [2:0][PROD_W-1:0] p_s1, q_s1;
	tsc_out_t               rd_item;

	always_comb begin
		// newest write first: the one finishing now, then the one just written
		if (ram_we && (ram_waddr == addr_s1)) begin
			fwd_word = s2_word;
		end else if (s3_valid_q && (s3_addr_q == addr_s1)) begin
			fwd_word = s3_word_q;
		end else begin
			fwd_word = WORD_BITS'(ram_rdata);
		end

		for (int i = 0; i < 3; i++) begin
			p_s1[i] = PROD_W'(ch_s1[i]) * PROD_W'(tint_q[i]);
			q_s1[i] = blend_s1 ? (PROD_W'(fwd_word[CH_W*i +: CH_W]) * PROD_W'(inv_s1)) : '0;
		end

		if (hit_s1) begin
			rd_item.out_red   = fwd_word[CH_W-1:0];
			rd_item.out_green = fwd_word[2*CH_W-1:CH_W];
			rd_item.out_blue  = fwd_word[3*CH_W-1:2*CH_W];
			rd_item.out_alpha = (BYTES_PER_PIXEL < 4) ? CH_MAX : fwd_word[4*CH_W-1:3*CH_W];
		end else begin
			rd_item = '0;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: sum, shift, saturate and write back
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= OP_NONE;
		end else begin
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2    <= addr_s1;
		p_s2       <= p_s1;
		q_s2       <= q_s1;
		wr_word_s2 <= ch_s1;
	end

	logic [2:0][CH_W-1:0] mix;
	logic [PROD_W:0]      mix_sum;

	always_comb begin
		mix_sum = '0;
		for (int i = 0; i < 3; i++) begin
			mix_sum = {1'b0, p_s2[i]} + {1'b0, q_s2[i]};
			mix[i]  = mix_sum[PROD_W] ? CH_MAX : mix_sum[PROD_W-1:CH_W];
		end

		unique case (op_s2)
			OP_DRAW:           s2_word = {CH_MAX, mix[2], mix[1], mix[0]};
			OP_WRITE:          s2_word = wr_word_s2;
			OP_NONE, OP_READ:  s2_word = wr_word_s2;
		endcase

		ram_we    = (op_s2 == OP_DRAW) || (op_s2 == OP_WRITE);
		ram_waddr = addr_s2;
		ram_wdata = s2_word[WORD_W-1:0];
	end

	// last write held in a register for reads issued while it was landing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else begin
			s3_valid_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		s3_addr_q <= ram_waddr;
		s3_word_q <= s2_word;
	end

	// ------------------------------------------------------------------
	// result fifo: decouples the pipe from a stalled consumer
	// ------------------------------------------------------------------
	tsc_out_t             ofifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] ofifo_wr_q, ofifo_rd_q;
	logic                 ofifo_push, ofifo_pop;

	assign ofifo_push   = op_s1 == OP_READ;
	assign ofifo_pop    = result.valid && result.ready;
	assign result.valid = ofifo_cnt_q != '0;
	assign result.data  = ofifo_q[ofifo_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofifo_wr_q  <= '0;
			ofifo_rd_q  <= '0;
			ofifo_cnt_q <= '0;
		end else begin
			if (ofifo_push) begin
				ofifo_wr_q <= ofifo_wr_q + 1'b1;
			end
			if (ofifo_pop) begin
				ofifo_rd_q <= ofifo_rd_q + 1'b1;
			end
			ofifo_cnt_q <= ofifo_cnt_q + OUT_CNT_W'(ofifo_push) - OUT_CNT_W'(ofifo_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ofifo_push) begin
			ofifo_q[ofifo_wr_q] <= rd_item;
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`TSC_ASSERT_IMP(a_fifo_bound, 1'b1, ofifo_cnt_q <= OUT_CNT_W'(OUT_DEPTH))
	`TSC_ASSERT_IMP(a_place_idle_draw, place_res.done, !draw_active_q)
	`TSC_ASSERT_NXT(a_read_issued, acc && (act == ACT_READ), op_s1 == OP_READ)
	`TSC_ASSERT_NXT(a_fwd_tracks_write, ram_we, s3_valid_q && (s3_addr_q == $past(ram_waddr)))

endmodule
